### hdl/aoi_pkg.sv
// aoi_pkg: shared constants, command struct and arctangent table for the
// ackermann odometry integrator; used by every file under hdl but aoi_if
`default_nettype none

package aoi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int HEADING_BITS_DEF = 16;

    // cordic word width, q2.30 with headroom
    localparam int CW       = 34;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;
    localparam int TNW      = CW - 14;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0]          TWO_PI_Q29  = 32'd3373259426;
    localparam logic [26:0]          TWO_PI_Q24  = 27'd105414357;
    localparam logic signed [15:0]   STEER_LIMIT = 16'sd19661;

    localparam logic [15:0] WHEELBASE_RST = 16'd384;
    localparam logic [15:0] TICK_RST      = 16'd3277;

    localparam logic CFG_WHEELBASE = 1'b0;
    localparam logic CFG_TICK      = 1'b1;

    typedef struct packed {
        logic             capture;
        logic             load_head;
        logic             load_steer;
        logic             cordic_step;
        logic             mul_a;
        logic             mul_b;
        logic             pos_upd;
        logic             tan_prep;
        logic             tan_mul;
        logic             dp_mul;
        logic             div_step;
        logic             yaw_upd;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } aoi_cmd_t;

    function automatic logic signed [CW-1:0] atan_lut(input logic [IDX_W-1:0] i);
        logic signed [CW-1:0] a;
        case (i)
            5'd0:    a = 34'sd843314856;
            5'd1:    a = 34'sd497837829;
            5'd2:    a = 34'sd263043836;
            5'd3:    a = 34'sd133525158;
            5'd4:    a = 34'sd67021686;
            5'd5:    a = 34'sd33543515;
            5'd6:    a = 34'sd16775850;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194282;
            5'd9:    a = 34'sd2097149;
            5'd10:   a = 34'sd1048575;
            5'd11:   a = 34'sd524287;
            5'd12:   a = 34'sd262143;
            5'd13:   a = 34'sd131071;
            5'd14:   a = 34'sd65535;
            5'd15:   a = 34'sd32767;
            5'd16:   a = 34'sd16383;
            5'd17:   a = 34'sd8191;
            5'd18:   a = 34'sd4095;
            5'd19:   a = 34'sd2047;
            5'd20:   a = 34'sd1023;
            5'd21:   a = 34'sd511;
            5'd22:   a = 34'sd255;
            5'd23:   a = 34'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### hdl/aoi_if.sv
// aoi_in_if and aoi_out_if: valid/ready channels for speed/steer items
// and pose results; depends on nothing
`default_nettype none

interface aoi_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] speed;
    logic signed [15:0] steer;

    modport source (output valid, output speed, output steer, input ready);
    modport sink   (input valid, input speed, input steer, output ready);
endinterface

interface aoi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [15:0] heading;

    modport source (output valid, output pose_x, output pose_y, output heading, input ready);
    modport sink   (input valid, input pose_x, input pose_y, input heading, output ready);
endinterface

`default_nettype wire

### hdl/ackermann_odometry_integrator_top.sv
// channel  | dir | transfer when      | payload
// item     | in  | valid && ready     | speed q4.12, steer q2.14
// result   | out | valid && ready     | pose_x, pose_y q16.16, heading
// cfg      | in  | cfg_we             | cfg_index, cfg_data
//
// one item at a time: each item runs the shared cordic unit twice and then
// the one-bit-a-cycle divider
// a finished pose sits in the result register; the next item is taken meanwhile
// a stalled result only holds the block once the next pose is ready
// reset clears the pose to zero and loads the default wheelbase and tick
// depends on aoi_pkg, aoi_if, aoi_ctrl, aoi_datapath
`default_nettype none

module ackermann_odometry_integrator_top
    import aoi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int HEADING_BITS = HEADING_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    aoi_in_if.sink           item,
    aoi_out_if.source        result,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    aoi_cmd_t cmd;

    aoi_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .HEADING_BITS (HEADING_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    aoi_datapath #(
        .HEADING_BITS (HEADING_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .speed     (item.speed),
        .steer     (item.steer),
        .pose_x    (result.pose_x),
        .pose_y    (result.pose_y),
        .heading   (result.heading)
    );

endmodule

`default_nettype wire

### hdl/aoi_cordic.sv
// aoi_cordic: iterative rotation-mode cordic, one micro-rotation per cycle while step is high
// depends on aoi_pkg
`default_nettype none

module aoi_cordic
    import aoi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire logic signed [CW-1:0] z_load,
    input  wire logic                 step,
    input  wire logic [IDX_W-1:0]     idx,
    output logic signed [CW-1:0]      cos_out,
    output logic signed [CW-1:0]      sin_out
);

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] xs, ys, a;

    assign xs = x_reg >>> idx;
    assign ys = y_reg >>> idx;
    assign a  = atan_lut(idx);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= z_load;
        end
        else if (step)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - a;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + a;
            end
        end
    end

    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

`default_nettype wire

### hdl/aoi_datapath.sv
// aoi_datapath: pose state, config registers, multipliers, serial divider
// and result register; depends on aoi_pkg and aoi_cordic
`default_nettype none

module aoi_datapath
    import aoi_pkg::*;
#(
    parameter int HEADING_BITS = HEADING_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire aoi_cmd_t           cmd,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic signed [15:0] speed,
    input  wire logic signed [15:0] steer,
    output logic signed [31:0]      pose_x,
    output logic signed [31:0]      pose_y,
    output logic [15:0]             heading
);

    localparam int H   = HEADING_BITS;
    localparam int PW  = H - 2 + 32;
    localparam int NW  = 32 + TNW;
    localparam int RW  = 16 + TNW + 27;
    localparam int SW  = NW - 26;
    localparam logic [H-3:0] EIGHTH = (H-2)'(1) << (H - 3);

    logic [15:0] wb_reg, tick_reg;
    logic signed [15:0] v_reg, phi_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [H-1:0] yaw_reg, q_reg;
    logic [1:0] quad_reg;
    logic signed [CW-1:0] hc_reg, hs_reg;
    logic signed [32:0] pdt_reg;
    logic signed [CW+32:0] px_reg, py_reg;
    logic [TNW-1:0] tn_reg, td_reg;
    logic neg_reg;
    logic [31:0] n1_reg;
    logic [NW-1:0] n_reg;
    logic [15+TNW:0] dp1_reg;
    logic [RW-1:0] dp_reg, rem_reg;
    logic [SW-1:0] sh_reg;
    logic signed [31:0] pose_x_reg, pose_y_reg;
    logic [15:0] heading_reg;
    logic [15:0] heading_next;

    // heading residual to q30 radians
    logic [H-1:0] shifted;
    logic [H-3:0] mag;
    logic res_neg;
    logic [PW-1:0] prod;
    logic [30:0] mag_q;
    logic signed [CW-1:0] rad, z_sel, steer_z, c_out, s_out;

    assign shifted = yaw_reg + H'(EIGHTH);
    assign res_neg = shifted[H-3:0] < EIGHTH;
    assign mag     = res_neg ? EIGHTH - shifted[H-3:0] : shifted[H-3:0] - EIGHTH;
    assign prod    = PW'(mag) * PW'(TWO_PI_Q29) + (PW'(1) << (H - 2));
    assign mag_q   = prod[PW-1:H-1];
    assign rad     = res_neg ? -$signed({3'b000, mag_q}) : $signed({3'b000, mag_q});
    assign steer_z = {{(CW-32){phi_reg[15]}}, phi_reg, 16'h0000};
    assign z_sel   = cmd.load_head ? rad : steer_z;

    aoi_cordic u_cordic (
        .clk     (clk),
        .load    (cmd.load_head | cmd.load_steer),
        .z_load  (z_sel),
        .step    (cmd.cordic_step),
        .idx     (cmd.idx),
        .cos_out (c_out),
        .sin_out (s_out)
    );

    // position move
    logic signed [32:0] pdt_mul;
    logic signed [CW+32:0] rnd_x, rnd_y;
    logic signed [33:0] sum_x, sum_y;
    logic signed [31:0] sat_x, sat_y;
    logic signed [15:0] phi_clip;

    assign pdt_mul = v_reg * $signed({1'b0, tick_reg});
    assign rnd_x   = px_reg + ((CW+33)'(1) <<< 41);
    assign rnd_y   = py_reg + ((CW+33)'(1) <<< 41);
    assign sum_x   = 34'(pos_x_reg) + 34'($signed(rnd_x[CW+32:42]));
    assign sum_y   = 34'(pos_y_reg) + 34'($signed(rnd_y[CW+32:42]));

    function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
        logic signed [31:0] r;
        if (s[33:31] == 3'b000 || s[33:31] == 3'b111)
            r = s[31:0];
        else if (s[33])
            r = 32'sh8000_0000;
        else
            r = 32'sh7fff_ffff;
        return r;
    endfunction

    assign sat_x = sat32(sum_x);
    assign sat_y = sat32(sum_y);

    always_comb
    begin
        if (steer > STEER_LIMIT)
            phi_clip = STEER_LIMIT;
        else if (steer < -STEER_LIMIT)
            phi_clip = -STEER_LIMIT;
        else
            phi_clip = steer;
    end

    // tangent terms, q16
    logic signed [TNW-1:0] tn_s, td_s;
    logic [15:0] v_abs, wb_eff;
    assign tn_s   = s_out[CW-1:14];
    assign td_s   = c_out[CW-1:14];
    assign v_abs  = v_reg[15] ? 16'(-v_reg) : 16'(v_reg);
    assign wb_eff = (wb_reg == '0) ? 16'd1 : wb_reg;

    // divider step
    logic [RW:0] r2;
    logic ge;
    assign r2 = {rem_reg, sh_reg[SW-1]};
    assign ge = r2 >= {1'b0, dp_reg};

    logic round_up;
    logic [H-1:0] q_fin;
    assign round_up = {rem_reg, 1'b0} >= {1'b0, dp_reg};
    assign q_fin    = q_reg + H'(round_up);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg    <= WHEELBASE_RST;
            tick_reg  <= TICK_RST;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            yaw_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WHEELBASE: wb_reg   <= cfg_data;
                    CFG_TICK:      tick_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if (cmd.pos_upd)
            begin
                pos_x_reg <= sat_x;
                pos_y_reg <= sat_y;
            end
            if (cmd.yaw_upd)
                yaw_reg <= neg_reg ? yaw_reg - q_fin : yaw_reg + q_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            v_reg   <= speed;
            phi_reg <= phi_clip;
        end
        if (cmd.load_head)
            quad_reg <= shifted[H-1:H-2];
        if (cmd.mul_a)
        begin
            pdt_reg <= pdt_mul;
            case (quad_reg)
                2'd0:    begin hc_reg <= c_out;  hs_reg <= s_out;  end
                2'd1:    begin hc_reg <= -s_out; hs_reg <= c_out;  end
                2'd2:    begin hc_reg <= -c_out; hs_reg <= -s_out; end
                default: begin hc_reg <= s_out;  hs_reg <= -c_out; end
            endcase
        end
        if (cmd.mul_b)
        begin
            px_reg <= pdt_reg * hc_reg;
            py_reg <= pdt_reg * hs_reg;
        end
        if (cmd.tan_prep)
        begin
            tn_reg  <= tn_s[TNW-1] ? TNW'(-tn_s) : TNW'(tn_s);
            td_reg  <= (td_s[TNW-1] || td_s == '0) ? TNW'(1) : TNW'(td_s);
            neg_reg <= v_reg[15] != tn_s[TNW-1];
            n1_reg  <= v_abs * tick_reg;
        end
        if (cmd.tan_mul)
        begin
            n_reg   <= NW'(n1_reg) * NW'(tn_reg);
            dp1_reg <= (16+TNW)'(wb_eff) * (16+TNW)'(td_reg);
        end
        if (cmd.dp_mul)
        begin
            dp_reg  <= RW'(dp1_reg) * RW'(TWO_PI_Q24);
            // top bits are always below the divisor
            rem_reg <= RW'(n_reg[NW-1:SW]);
            sh_reg  <= n_reg[SW-1:0];
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? RW'(r2 - {1'b0, dp_reg}) : r2[RW-1:0];
            sh_reg  <= {sh_reg[SW-2:0], 1'b0};
            q_reg   <= {q_reg[H-2:0], ge};
        end
        if (cmd.out_load)
        begin
            pose_x_reg  <= pos_x_reg;
            pose_y_reg  <= pos_y_reg;
            heading_reg <= heading_next;
        end
    end

    generate
        if (H >= 16)
        begin : g_head_hi
            assign heading_next = yaw_reg[H-1 -: 16];
        end
        else
        begin : g_head_lo
            assign heading_next = {yaw_reg, (16-H)'(0)};
        end
    endgenerate

    assign pose_x  = pose_x_reg;
    assign pose_y  = pose_y_reg;
    assign heading = heading_reg;

endmodule

`default_nettype wire

### hdl/aoi_ctrl.sv
// aoi_ctrl: sequencer for one odometry step and the result valid flag
// depends on aoi_pkg
`default_nettype none

module aoi_ctrl
    import aoi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int HEADING_BITS = HEADING_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output aoi_cmd_t  cmd
);

    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(32 + TNW - 26 + HEADING_BITS + 4 - 1);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_HPREP = 13'b0000000000010,
        S_HCORD = 13'b0000000000100,
        S_MULA  = 13'b0000000001000,
        S_MULB  = 13'b0000000010000,
        S_POS   = 13'b0000000100000,
        S_SCORD = 13'b0000001000000,
        S_TPREP = 13'b0000010000000,
        S_TMUL  = 13'b0000100000000,
        S_DMUL  = 13'b0001000000000,
        S_DIV   = 13'b0010000000000,
        S_FIN   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.idx        = cnt_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_HPREP;
                end
            end
            S_HPREP:
            begin
                cmd.load_head = 1'b1;
                cnt_next      = '0;
                state_next    = S_HCORD;
            end
            S_HCORD:
            begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == CORD_LAST)
                    state_next = S_MULA;
            end
            S_MULA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.mul_b  = 1'b1;
                state_next = S_POS;
            end
            S_POS:
            begin
                cmd.pos_upd    = 1'b1;
                cmd.load_steer = 1'b1;
                cnt_next       = '0;
                state_next     = S_SCORD;
            end
            S_SCORD:
            begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == CORD_LAST)
                    state_next = S_TPREP;
            end
            S_TPREP:
            begin
                cmd.tan_prep = 1'b1;
                state_next   = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.tan_mul = 1'b1;
                state_next  = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.dp_mul = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.yaw_upd = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking bench for ackermann_odometry_integrator_top; drives speed/steer
// items through bursts and gaps and checks every pose against a bit-true dead reckoner
// or a fixed expected pose; depends on aoi_pkg, aoi_if and the rtl under hdl
`default_nettype none

module tb_top;
    import aoi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  SETTLE      = 200;
    localparam int  STEER_CLIP  = 19661;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [15:0] hdg;
    } pose_t;

    typedef struct {
        logic signed [15:0] speed;
        logic signed [15:0] steer;
        bit                 typed;
        pose_t              pose;
    } stim_row_t;

    localparam longint ATAN_Q30 [16] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_WHEELBASE;
    logic [15:0] cfg_data = '0;

    aoi_in_if  item_ch ();
    aoi_out_if res_ch ();

    ackermann_odometry_integrator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // reckoner state, mirrors the block
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic        [15:0] est_yaw;
    logic        [15:0] wheelbase_reg;
    logic        [15:0] tick_reg;

    pose_t pose_q[$];
    int    n_errors = 0;
    int    n_items = 0;
    int    n_poses = 0;
    int    cycles = 0;
    int    burst_left = 0;

    function automatic void rotate(input longint z, output longint c, output longint s);
        longint x, y, xs, ys;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - ATAN_Q30[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + ATAN_Q30[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // advance the pose by one tick, heading trig taken from the old yaw
    function automatic pose_t reckon(input logic signed [15:0] speed, input logic signed [15:0] steer);
        logic [15:0] shifted;
        logic [1:0]  quad;
        longint      resid, mag, rad, c, s, hc, hs, v, phi, tn, td, p;
        logic [63:0] num, den, q, r;
        bit          neg;
        pose_t       o;
        shifted = est_yaw + 16'd8192;
        quad    = shifted[15:14];
        resid   = longint'(shifted[13:0]) - 8192;
        mag     = (resid < 0) ? -resid : resid;
        mag     = (mag * 64'd3373259426 + (64'd1 << 14)) >> 15;
        rad     = (resid < 0) ? -mag : mag;
        rotate(rad, c, s);
        case (quad)
            2'd0:    begin hc = c;  hs = s;  end
            2'd1:    begin hc = -s; hs = c;  end
            2'd2:    begin hc = -c; hs = -s; end
            default: begin hc = s;  hs = -c; end
        endcase
        v = speed;
        p = v * hc * longint'(tick_reg);
        est_x = clamp32(longint'(est_x) + ((p + (64'sd1 <<< 41)) >>> 42));
        p = v * hs * longint'(tick_reg);
        est_y = clamp32(longint'(est_y) + ((p + (64'sd1 <<< 41)) >>> 42));

        phi = steer;
        if (phi > STEER_CLIP)
            phi = STEER_CLIP;
        if (phi < -STEER_CLIP)
            phi = -STEER_CLIP;
        rotate(phi * 65536, c, s);
        tn = s >>> 14;
        td = c >>> 14;
        if (td < 1)
            td = 1;
        neg = (v < 0) != (tn < 0);
        num = 64'((v < 0) ? -v : v) * 64'((tn < 0) ? -tn : tn) * 64'(tick_reg);
        den = 64'((wheelbase_reg == 0) ? 16'd1 : wheelbase_reg) * 64'(td) * 64'd105414357;
        q = num / den;
        r = num % den;
        for (int k = 0; k < 20; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        if ((r << 1) >= den)
            q = q + 1;
        if (neg)
            q = -q;
        est_yaw = est_yaw + q[15:0];
        o.x = est_x;
        o.y = est_y;
        o.hdg = est_yaw;
        return o;
    endfunction

    task automatic offer_item(input logic signed [15:0] speed, input logic signed [15:0] steer,
                              input bit typed, input pose_t typed_pose);
        pose_t p;
        int gap;
        item_ch.valid <= 1'b1;
        item_ch.speed <= speed;
        item_ch.steer <= steer;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        p = reckon(speed, steer);
        pose_q.insert(pose_q.size(), typed ? typed_pose : p);
        n_items++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 120);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop offering and wait until every pose has come out, block back to idle
    task automatic drain;
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WHEELBASE)
            wheelbase_reg = val;
        else
            tick_reg = val;
        @(posedge clk);
    endtask

    task automatic random_run(input int count);
        logic signed [15:0] sp, st;
        pose_t none;
        none = '{default: '0};
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 7))
                0:       sp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                1:       sp = '0;
                default: sp = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       st = 16'($urandom);
                1:       st = $urandom_range(0, 1) ? 16'(STEER_CLIP) : 16'(-STEER_CLIP);
                default: st = 16'(int'($urandom_range(0, 2 * STEER_CLIP)) - STEER_CLIP);
            endcase
            offer_item(sp, st, 1'b0, none);
            if (i == count / 2 && $urandom_range(0, 1) == 0)
                drain();
        end
    endtask

    // receiver: checks each transfer, stalls in changing modes with one long hold-off
    initial
    begin
        int mode, mode_left, hold;
        pose_t e;
        mode = 0;
        mode_left = 0;
        hold = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                n_poses++;
                if (pose_q.size() == 0)
                begin
                    n_errors++;
                    $error("pose transfer with nothing expected");
                end
                else
                begin
                    e = pose_q.pop_front();
                    if (res_ch.pose_x !== e.x)
                    begin
                        n_errors++;
                        $error("pose_x expected %0d actual %0d", e.x, res_ch.pose_x);
                    end
                    if (res_ch.pose_y !== e.y)
                    begin
                        n_errors++;
                        $error("pose_y expected %0d actual %0d", e.y, res_ch.pose_y);
                    end
                    if (res_ch.heading !== e.hdg)
                    begin
                        n_errors++;
                        $error("heading expected %0d actual %0d", e.hdg, res_ch.heading);
                    end
                end
                if (n_poses == 300)
                    hold = 1500;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 400);
            end
            mode_left--;
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    default: res_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL ackermann_odometry_integrator_top");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        pose_t none;
        none = '{default: '0};
        item_ch.valid = 1'b0;
        item_ch.speed = '0;
        item_ch.steer = '0;
        est_x = '0;
        est_y = '0;
        est_yaw = '0;
        wheelbase_reg = WHEELBASE_RST;
        tick_reg = TICK_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // straight after reset a standstill tick leaves the pose at zero
        rows.insert(rows.size(), stim_row_t'{16'sd0, 16'sd0, 1'b1, '{32'sd0, 32'sd0, 16'd0}});
        rows.insert(rows.size(), stim_row_t'{16'sd0, 16'sh7fff, 1'b1, '{32'sd0, 32'sd0, 16'd0}});
        rows.insert(rows.size(), stim_row_t'{16'sh7fff, 16'sd0, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{16'sh8000, 16'sd0, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{16'sd4096, 16'sh7fff, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{16'sd4096, 16'sh8000, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{16'sd4096, 16'sd19661, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{16'sd4096, -16'sd19661, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{16'sd4096, 16'sd19662, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{-16'sd4096, 16'sd8192, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{16'sh7fff, 16'sh7fff, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{16'sh8000, 16'sh8000, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{16'sh7fff, 16'sh8000, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{16'sd1, 16'sd1, 1'b0, none});
        rows.insert(rows.size(), stim_row_t'{-16'sd1, -16'sd1, 1'b0, none});
        for (int i = 0; i < 8; i++)
            rows.insert(rows.size(), stim_row_t'{16'sh7fff, 16'sd19661, 1'b0, none});
        foreach (rows[i])
            offer_item(rows[i].speed, rows[i].steer, rows[i].typed, rows[i].pose);
        drain();

        random_run(250);
        drain();
        write_reg(CFG_WHEELBASE, 16'd1);
        write_reg(CFG_TICK, 16'hffff);
        random_run(250);
        drain();
        write_reg(CFG_WHEELBASE, 16'hffff);
        write_reg(CFG_TICK, 16'd1);
        random_run(200);
        drain();
        // zero wheelbase acts as the smallest one, zero tick freezes the pose
        write_reg(CFG_WHEELBASE, 16'd0);
        random_run(100);
        drain();
        write_reg(CFG_TICK, 16'd0);
        random_run(100);
        drain();
        write_reg(CFG_WHEELBASE, 16'hffff);
        write_reg(CFG_TICK, 16'hffff);
        random_run(200);
        drain();
        write_reg(CFG_WHEELBASE, 16'($urandom_range(1, 2048)));
        write_reg(CFG_TICK, 16'($urandom_range(1, 65535)));
        random_run(400);
        drain();

        $display("covered %0d items and %0d poses over seven wheelbase/tick settings,",
                 n_items, n_poses);
        $display("with clipped steering, zero tick, zero wheelbase and output back-pressure");
        if (n_errors == 0 && pose_q.size() == 0)
            $display("PASS ackermann_odometry_integrator_top");
        else
            $display("FAIL ackermann_odometry_integrator_top");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hdl/aoi_pkg.sv
hdl/aoi_if.sv
hdl/aoi_cordic.sv
hdl/aoi_datapath.sv
hdl/aoi_ctrl.sv
hdl/ackermann_odometry_integrator_top.sv
tb/tb_top.sv
